// ===== design/wrmd_pkg.sv =====
// ----------------------------------------------------------------------------
// wrmd_pkg
// Shared widths, register indexes, queue word layouts and the decimal
// digit helpers for the windowed RMS meter.
// ----------------------------------------------------------------------------
`default_nettype none

package wrmd_pkg;

  // Field widths
  localparam int unsigned SAMPLE_W = 10;
  localparam int unsigned OFFSET_W = 10;
  localparam int unsigned SCALE_W  = 20;
  localparam int unsigned LEN_W    = 10;
  localparam int unsigned CFG_W    = 20;
  localparam int unsigned IDX_W    = 2;
  localparam int unsigned SQ_W     = 2 * SAMPLE_W;

  // Accumulator and back-end widths
  localparam int unsigned SUM_W      = 29;
  localparam int unsigned FRAC_W     = 16;
  localparam int unsigned QUO_W      = SUM_W + FRAC_W;
  localparam int unsigned ROOT_STEPS = (QUO_W + 1) / 2;
  localparam int unsigned ROOT_W     = ROOT_STEPS;
  localparam int unsigned PROD_W     = ROOT_W + SCALE_W;
  localparam int unsigned SHIFT_OUT  = 24;
  localparam int unsigned RAW_W      = PROD_W - SHIFT_OUT;
  localparam int unsigned VALUE_W    = 14;
  localparam int unsigned STEP_W     = 6;

  localparam logic [VALUE_W-1:0] VALUE_MAX = 14'd9999;

  // Configuration register indexes
  localparam logic [IDX_W-1:0] REG_MIDSCALE = 2'd0;
  localparam logic [IDX_W-1:0] REG_SCALE    = 2'd1;
  localparam logic [IDX_W-1:0] REG_WINDOW   = 2'd2;

  // Reset values of the configuration registers
  localparam logic [OFFSET_W-1:0] MIDSCALE_RST = 10'd512;
  localparam logic [SCALE_W-1:0]  SCALE_RST    = 20'd294400;
  localparam logic [LEN_W-1:0]    WINDOW_RST   = 10'd200;

  // Completed window handed from front to back
  typedef struct packed {
    logic [SUM_W-1:0] sum;
    logic [LEN_W-1:0] len;
  } win_t;

  // One output word
  typedef struct packed {
    logic [7:0] tagged_digit;
    logic       last;
  } digit_t;

  // Weight of the digit at position pos (3 = thousands ... 0 = units)
  function automatic logic [VALUE_W-1:0] place_value(input logic [1:0] pos);
    logic [VALUE_W-1:0] p;
    case (pos)
      2'd3:    p = 14'd1000;
      2'd2:    p = 14'd100;
      2'd1:    p = 14'd10;
      default: p = 14'd1;
    endcase
    return p;
  endfunction

  // Leading decimal digit of rem at weight p, rem below 10*p
  function automatic logic [3:0] digit_of(input logic [VALUE_W-1:0] rem,
                                          input logic [VALUE_W-1:0] p);
    logic [3:0] d;
    d = 4'd0;
    for (int k = 1; k < 10; k++) begin
      if ({4'd0, rem} >= 18'(k) * {4'd0, p}) d = 4'(k);
    end
    return d;
  endfunction

endpackage

`default_nettype wire

// ===== design/wrmd_fifo.sv =====
// ----------------------------------------------------------------------------
// wrmd_fifo
// Small first-word-fall-through queue used between the front and back
// ends and in front of the result ports.
// ----------------------------------------------------------------------------
`default_nettype none

module wrmd_fifo #(
  parameter int unsigned WIDTH = 8,
  parameter int unsigned DEPTH = 2
) (
  input  wire logic             clk_i,
  input  wire logic             rst_ni,
  input  wire logic             wr_en_i,
  input  wire logic [WIDTH-1:0] wr_data_i,
  input  wire logic             rd_en_i,
  output logic      [WIDTH-1:0] rd_data_o,
  output logic                  full_o,
  output logic                  empty_o
);

  localparam int unsigned PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int unsigned CNT_W = $clog2(DEPTH + 1);
  localparam logic [PTR_W-1:0] PTR_LAST = PTR_W'(DEPTH - 1);
  localparam logic [CNT_W-1:0] CNT_FULL = CNT_W'(DEPTH);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [PTR_W-1:0] wr_ptr_q, rd_ptr_q;
  logic [CNT_W-1:0] cnt_q;
  logic             do_wr, do_rd;

  assign full_o    = (cnt_q == CNT_FULL);
  assign empty_o   = (cnt_q == '0);
  assign do_wr     = wr_en_i && !full_o;
  assign do_rd     = rd_en_i && !empty_o;
  assign rd_data_o = mem_q[rd_ptr_q];

  // Storage
  always_ff @(posedge clk_i) begin
    if (do_wr) mem_q[wr_ptr_q] <= wr_data_i;
  end

  // Pointers and fill count
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      cnt_q    <= '0;
    end else begin
      if (do_wr) wr_ptr_q <= (wr_ptr_q == PTR_LAST) ? '0 : wr_ptr_q + 1'b1;
      if (do_rd) rd_ptr_q <= (rd_ptr_q == PTR_LAST) ? '0 : rd_ptr_q + 1'b1;
      if (do_wr && !do_rd)      cnt_q <= cnt_q + 1'b1;
      else if (do_rd && !do_wr) cnt_q <= cnt_q - 1'b1;
    end
  end

endmodule

`default_nettype wire

// ===== design/wrmd_front.sv =====
// ----------------------------------------------------------------------------
// wrmd_front
// Sample accumulator: removes the midscale offset, squares the difference
// and adds it into a saturating sum; hands each completed window on.
// ----------------------------------------------------------------------------
`default_nettype none

module wrmd_front
  import wrmd_pkg::*;
#(
  parameter int unsigned SAMPLE_BITS = 10
) (
  input  wire logic                clk_i,
  input  wire logic                rst_ni,
  input  wire logic                accept_i,
  input  wire logic [SAMPLE_W-1:0] sample_i,
  input  wire logic [OFFSET_W-1:0] offset_i,
  input  wire logic [LEN_W-1:0]    len_i,
  output logic                     win_push_o,
  output win_t                     win_o
);

  logic [SUM_W-1:0]    sum_q;
  logic [LEN_W-1:0]    cnt_q;
  logic [SAMPLE_W-1:0] smp, mag;
  logic [SQ_W-1:0]     sq;
  logic [SUM_W:0]      sum_ext;
  logic [SUM_W-1:0]    sum_sat;
  logic [LEN_W:0]      cnt_inc;
  logic                done;

  // Keep only the converter's bits
  always_comb begin
    for (int i = 0; i < SAMPLE_W; i++) begin
      smp[i] = sample_i[i] & (i < SAMPLE_BITS);
    end
  end

  // Magnitude, square and saturating sum
  assign mag     = (smp >= offset_i) ? smp - offset_i : offset_i - smp;
  assign sq      = mag * mag;
  assign sum_ext = {1'b0, sum_q} + (SUM_W + 1)'(sq);
  assign sum_sat = sum_ext[SUM_W] ? '1 : sum_ext[SUM_W-1:0];
  assign cnt_inc = {1'b0, cnt_q} + 1'b1;
  assign done    = (cnt_inc >= {1'b0, len_i});

  assign win_push_o = accept_i && done;
  assign win_o      = '{sum: sum_sat, len: len_i};

  // Window state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      sum_q <= '0;
      cnt_q <= '0;
    end else if (accept_i) begin
      if (done) begin
        sum_q <= '0;
        cnt_q <= '0;
      end else begin
        sum_q <= sum_sat;
        cnt_q <= cnt_inc[LEN_W-1:0];
      end
    end
  end

  a_close_clears : assert property (@(posedge clk_i) disable iff (!rst_ni)
    accept_i && done |=> sum_q == '0 && cnt_q == '0)
    else $error("window state not cleared after report");

  a_count_step : assert property (@(posedge clk_i) disable iff (!rst_ni)
    accept_i && !done |=> cnt_q == $past(cnt_inc[LEN_W-1:0]))
    else $error("sample count did not advance by one");

  a_idle_hold : assert property (@(posedge clk_i) disable iff (!rst_ni)
    !accept_i |=> $stable(sum_q) && $stable(cnt_q))
    else $error("window state moved without a sample");

endmodule

`default_nettype wire

// ===== design/wrmd_back.sv =====
// ----------------------------------------------------------------------------
// wrmd_back
// Report sequencer: bit-serial divide by the window length, bit-pair square root,
// scale multiply, saturation and one decimal digit per cycle while out_full is low.
// ----------------------------------------------------------------------------
`default_nettype none

module wrmd_back
  import wrmd_pkg::*;
(
  input  wire logic               clk_i,
  input  wire logic               rst_ni,
  input  wire logic               win_valid_i,
  input  wire win_t               win_i,
  output logic                    win_pop_o,
  input  wire logic [SCALE_W-1:0] scale_i,
  input  wire logic               out_full_i,
  output logic                    out_push_o,
  output digit_t                  out_word_o
);

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_DIV,
    ST_SQRT,
    ST_MUL,
    ST_SAT,
    ST_DIG
  } state_e;

  localparam logic [STEP_W-1:0] DIV_LAST  = STEP_W'(QUO_W - 1);
  localparam logic [STEP_W-1:0] ROOT_LAST = STEP_W'(ROOT_STEPS - 1);
  localparam logic [QUO_W-1:0]  BIT_TOP   = QUO_W'(1) << (2 * (ROOT_STEPS - 1));

  state_e             state_q;
  logic [STEP_W-1:0]  step_q;
  logic [QUO_W-1:0]   acc_q;     // dividend/quotient, then root remainder
  logic [LEN_W-1:0]   rem_q;
  logic [LEN_W-1:0]   len_q;
  logic [QUO_W-1:0]   res_q;
  logic [QUO_W-1:0]   bit_q;
  logic [PROD_W-1:0]  prod_q;
  logic [VALUE_W-1:0] val_q;
  logic [1:0]         pos_q;

  logic [LEN_W:0]     div_sh;
  logic               div_ge;
  logic [LEN_W-1:0]   div_rem;
  logic [QUO_W:0]     trial;
  logic               root_ge;
  logic [RAW_W-1:0]   raw;
  logic [VALUE_W-1:0] sat_val;
  logic [VALUE_W-1:0] weight;
  logic [3:0]         dig;

  // Restoring division step
  assign div_sh  = {rem_q, acc_q[QUO_W-1]};
  assign div_ge  = (div_sh >= {1'b0, len_q});
  assign div_rem = div_ge ? LEN_W'(div_sh - {1'b0, len_q}) : div_sh[LEN_W-1:0];

  // Square root step
  assign trial   = {1'b0, res_q} + {1'b0, bit_q};
  assign root_ge = ({1'b0, acc_q} >= trial);

  // Scaled value, clipped to four digits
  assign raw     = prod_q[PROD_W-1:SHIFT_OUT];
  assign sat_val = (raw > RAW_W'(VALUE_MAX)) ? VALUE_MAX : raw[VALUE_W-1:0];

  // Digit extraction
  assign weight = place_value(pos_q);
  assign dig    = digit_of(val_q, weight);

  assign win_pop_o  = (state_q == ST_IDLE) && win_valid_i;
  assign out_push_o = (state_q == ST_DIG) && !out_full_i;
  assign out_word_o = '{tagged_digit: {2'b00, pos_q, dig}, last: (pos_q == 2'd0)};

  // Sequencer
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
      step_q  <= '0;
      acc_q   <= '0;
      rem_q   <= '0;
      len_q   <= '0;
      res_q   <= '0;
      bit_q   <= '0;
      prod_q  <= '0;
      val_q   <= '0;
      pos_q   <= '0;
    end else begin
      unique case (state_q)
        ST_IDLE: begin
          if (win_valid_i) begin
            acc_q   <= {win_i.sum, FRAC_W'(0)};
            len_q   <= win_i.len;
            rem_q   <= '0;
            step_q  <= DIV_LAST;
            state_q <= ST_DIV;
          end
        end
        ST_DIV: begin
          rem_q <= div_rem;
          acc_q <= {acc_q[QUO_W-2:0], div_ge};
          if (step_q == '0) begin
            res_q   <= '0;
            bit_q   <= BIT_TOP;
            step_q  <= ROOT_LAST;
            state_q <= ST_SQRT;
          end else begin
            step_q <= step_q - 1'b1;
          end
        end
        ST_SQRT: begin
          if (root_ge) begin
            acc_q <= acc_q - trial[QUO_W-1:0];
            res_q <= (res_q >> 1) + bit_q;
          end else begin
            res_q <= res_q >> 1;
          end
          bit_q <= bit_q >> 2;
          if (step_q == '0) state_q <= ST_MUL;
          else              step_q  <= step_q - 1'b1;
        end
        ST_MUL: begin
          prod_q  <= res_q[ROOT_W-1:0] * scale_i;
          state_q <= ST_SAT;
        end
        ST_SAT: begin
          val_q   <= sat_val;
          pos_q   <= 2'd3;
          state_q <= ST_DIG;
        end
        ST_DIG: begin
          if (!out_full_i) begin
            val_q <= val_q - VALUE_W'({10'd0, dig} * weight);
            if (pos_q == 2'd0) state_q <= ST_IDLE;
            else               pos_q   <= pos_q - 1'b1;
          end
        end
        default: state_q <= ST_IDLE;
      endcase
    end
  end

  a_push_in_dig : assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_push_o |-> state_q == ST_DIG)
    else $error("digit word pushed outside digit phase");

  a_digit_range : assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q == ST_DIG |-> dig <= 4'd9)
    else $error("digit out of decimal range");

  a_last_ends : assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_push_o && out_word_o.last |=> state_q == ST_IDLE)
    else $error("sequencer did not return to idle after units digit");

endmodule

`default_nettype wire

// ===== design/windowed_rms_meter_digits_core.sv =====
// ----------------------------------------------------------------------------
// windowed_rms_meter_digits_core
// Windowed RMS meter reporting four tagged decimal digits per window.
// ----------------------------------------------------------------------------
// Samples are taken one per clock while full is low: the front end squares
// each one and adds it into its registered sum as it is taken. A completed
// window goes through a two-entry queue to the back end, which loads it and
// then runs 45 restoring-division steps (sum*2^16 / length), 23 square-root
// steps, one multiply, one saturation and four digit words; the digit words
// stall while the result queue is full. The serial divider and root are most
// of that work. With windows longer than that work and a drained result queue,
// samples run at one per cycle indefinitely; shorter windows raise full while both queued windows wait.
// Digits come out thousands first, tagged 0x3-, 0x2-, 0x1-, 0x0-, with
// last set on the units word.
`default_nettype none

module windowed_rms_meter_digits_core
  import wrmd_pkg::*;
#(
  parameter int unsigned SAMPLE_BITS = 10,
  parameter int unsigned MAX_WINDOW  = 1023
) (
  input  wire logic                clk_i,
  input  wire logic                rst_ni,
  // sample side
  input  wire logic                push,
  output logic                     full,
  input  wire logic [SAMPLE_W-1:0] sample_i,
  // result side
  output logic                     empty,
  input  wire logic                pop,
  output logic [7:0]               tagged_digit_o,
  output logic                     last_o,
  // configuration
  input  wire logic                cfg_we_i,
  input  wire logic [IDX_W-1:0]    cfg_idx_i,
  input  wire logic [CFG_W-1:0]    cfg_wdata_i
);

  localparam int unsigned WIN_DEPTH = 2;
  localparam int unsigned OUT_DEPTH = 2;

  logic [OFFSET_W-1:0] midscale_q;
  logic [SCALE_W-1:0]  scale_q;
  logic [LEN_W-1:0]    window_q;
  logic [LEN_W-1:0]    len_nz, len_eff;

  logic   accept;
  logic   win_push, win_pop, win_full, win_empty;
  win_t   win_in, win_out;
  logic   out_push, out_full;
  digit_t out_in, out_out;

  // Configuration registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      midscale_q <= MIDSCALE_RST;
      scale_q    <= SCALE_RST;
      window_q   <= WINDOW_RST;
    end else if (cfg_we_i) begin
      unique case (cfg_idx_i)
        REG_MIDSCALE: midscale_q <= cfg_wdata_i[OFFSET_W-1:0];
        REG_SCALE:    scale_q    <= cfg_wdata_i[SCALE_W-1:0];
        REG_WINDOW:   window_q   <= cfg_wdata_i[LEN_W-1:0];
        default:      ;
      endcase
    end
  end

  // Effective window length: zero acts as one, clamp at the maximum
  assign len_nz  = (window_q == '0) ? LEN_W'(1) : window_q;
  assign len_eff = ({7'd0, len_nz} > 17'(MAX_WINDOW)) ? LEN_W'(MAX_WINDOW) : len_nz;

  assign full   = win_full;
  assign accept = push && !win_full;

  wrmd_front #(
    .SAMPLE_BITS (SAMPLE_BITS)
  ) u_front (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .accept_i   (accept),
    .sample_i   (sample_i),
    .offset_i   (midscale_q),
    .len_i      (len_eff),
    .win_push_o (win_push),
    .win_o      (win_in)
  );

  // Completed windows waiting for the back end
  wrmd_fifo #(
    .WIDTH ($bits(win_t)),
    .DEPTH (WIN_DEPTH)
  ) u_win_q (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .wr_en_i   (win_push),
    .wr_data_i (win_in),
    .rd_en_i   (win_pop),
    .rd_data_o (win_out),
    .full_o    (win_full),
    .empty_o   (win_empty)
  );

  wrmd_back u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .win_valid_i (!win_empty),
    .win_i       (win_out),
    .win_pop_o   (win_pop),
    .scale_i     (scale_q),
    .out_full_i  (out_full),
    .out_push_o  (out_push),
    .out_word_o  (out_in)
  );

  // Result words
  wrmd_fifo #(
    .WIDTH ($bits(digit_t)),
    .DEPTH (OUT_DEPTH)
  ) u_out_q (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .wr_en_i   (out_push),
    .wr_data_i (out_in),
    .rd_en_i   (pop),
    .rd_data_o (out_out),
    .full_o    (out_full),
    .empty_o   (empty)
  );

  assign tagged_digit_o = out_out.tagged_digit;
  assign last_o         = out_out.last;

endmodule

`default_nettype wire
